// File: design/m3i_pkg.sv
// Shared constants, tables and types for the 3x3 matrix inverse pipeline.
`default_nettype none

package m3i_pkg;

    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // product, adjugate, det partial, det term, det sum, magnitudes
    localparam int FRONT_LAT = 6;

    // Operand pairs of the 18 products; adjugate k = prod[2k] - prod[2k+1].
    // Matrix elements are numbered row-major, 0..8.
    localparam int unsigned PROD_A [18] = '{4, 7, 2, 1, 1, 2, 5, 3, 0,
                                            2, 3, 0, 3, 6, 6, 0, 0, 3};
    localparam int unsigned PROD_B [18] = '{8, 5, 7, 8, 5, 4, 6, 8, 8,
                                            6, 2, 5, 7, 4, 1, 7, 4, 1};

    typedef struct packed {
        logic valid;
        logic sing;
    } ctl_t;

    // check stage, one stage per quotient bit, round, saturate
    function automatic int div_lat(input int ew);
        return ew + 3;
    endfunction

endpackage

`default_nettype wire

// File: design/m3i_div.sv
// Pipelined restoring divider lane: rounded, saturated signed quotient.
`default_nettype none

module m3i_div #(
    parameter int EW   = m3i_pkg::ELEM_WIDTH_DEF,
    parameter int NW   = 4 * m3i_pkg::ELEM_WIDTH_DEF,
    parameter int DENW = 3 * m3i_pkg::ELEM_WIDTH_DEF + 3
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [NW-1:0]        num,
    input  wire logic [DENW-1:0]      den,
    input  wire logic                 neg,
    input  wire logic                 zero,
    output logic signed [EW-1:0]      quo
);

    localparam int RW = ((NW > DENW + EW) ? NW : DENW + EW) + 1;

    logic [RW-1:0]   rem_reg [EW+1];
    logic [DENW-1:0] den_reg [EW+1];
    logic [EW-1:0]   quo_reg [EW+1];
    logic            ovf_reg [EW+1];
    logic            neg_reg [EW+1];
    logic            zero_reg[EW+1];

    logic [RW-1:0]   sh      [EW];
    logic            ge      [EW];

    logic [EW:0]     qr_reg;
    logic            ovf_r_reg;
    logic            neg_r_reg;
    logic            zero_r_reg;
    logic            up;

    logic [EW:0]     lim;
    logic [EW:0]     mag;
    logic [EW-1:0]   quo_next;
    logic [EW-1:0]   quo_out_reg;

    always_comb
    begin
        for (int j = 0; j < EW; j++)
        begin
            sh[j] = RW'(den_reg[j]) << (EW - 1 - j);
            ge[j] = rem_reg[j] >= sh[j];
        end
        up = {rem_reg[EW], 1'b0} >= (RW + 1)'(den_reg[EW]);
    end

    always_comb
    begin
        lim = neg_r_reg ? ((EW + 1)'(1) << (EW - 1))
                        : (((EW + 1)'(1) << (EW - 1)) - (EW + 1)'(1));
        mag = (ovf_r_reg || (qr_reg > lim)) ? lim : qr_reg;
        if (zero_r_reg)
            quo_next = '0;
        else if (neg_r_reg)
            quo_next = EW'(-mag);
        else
            quo_next = EW'(mag);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // quotient of 2^EW or more always saturates
            rem_reg[0]  <= RW'(num);
            den_reg[0]  <= den;
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= RW'(num) >= (RW'(den) << EW);
            neg_reg[0]  <= neg;
            zero_reg[0] <= zero;
            for (int j = 0; j < EW; j++)
            begin
                rem_reg[j+1]  <= ge[j] ? (rem_reg[j] - sh[j]) : rem_reg[j];
                quo_reg[j+1]  <= quo_reg[j] | (EW'(ge[j]) << (EW - 1 - j));
                den_reg[j+1]  <= den_reg[j];
                ovf_reg[j+1]  <= ovf_reg[j];
                neg_reg[j+1]  <= neg_reg[j];
                zero_reg[j+1] <= zero_reg[j];
            end
            // round half away from zero on the magnitude
            qr_reg      <= (EW + 1)'(quo_reg[EW]) + (EW + 1)'(up);
            ovf_r_reg   <= ovf_reg[EW];
            neg_r_reg   <= neg_reg[EW];
            zero_r_reg  <= zero_reg[EW];
            quo_out_reg <= quo_next;
        end
    end

    assign quo = quo_out_reg;

endmodule

`default_nettype wire

// File: design/matrix3_inverse.sv
// Top level of the 3x3 fixed-point matrix inverse pipeline.
// Takes one matrix word per cycle while the output is not stalled and returns its
// inverse, determinant and a singular flag, one word per cycle, in order. Six front
// stages form products, adjugate, determinant and magnitudes, then nine divider
// lanes run a restoring division that resolves one quotient bit per stage, followed
// by rounding and saturation. The determinant is rounded by a shift and delayed to
// line up with the inverse. A stall at the output freezes the whole pipeline;
// bubbles are carried along, not squeezed out.
`default_nettype none

module matrix3_inverse #(
    parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF,
    parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         mat_valid,
    output logic                              mat_ready,
    input  wire logic signed [ELEM_WIDTH-1:0] m_r0c0,
    input  wire logic signed [ELEM_WIDTH-1:0] m_r0c1,
    input  wire logic signed [ELEM_WIDTH-1:0] m_r0c2,
    input  wire logic signed [ELEM_WIDTH-1:0] m_r1c0,
    input  wire logic signed [ELEM_WIDTH-1:0] m_r1c1,
    input  wire logic signed [ELEM_WIDTH-1:0] m_r1c2,
    input  wire logic signed [ELEM_WIDTH-1:0] m_r2c0,
    input  wire logic signed [ELEM_WIDTH-1:0] m_r2c1,
    input  wire logic signed [ELEM_WIDTH-1:0] m_r2c2,
    output logic                              inv_valid,
    input  wire logic                         inv_ready,
    output logic signed [ELEM_WIDTH-1:0]      inv_r0c0,
    output logic signed [ELEM_WIDTH-1:0]      inv_r0c1,
    output logic signed [ELEM_WIDTH-1:0]      inv_r0c2,
    output logic signed [ELEM_WIDTH-1:0]      inv_r1c0,
    output logic signed [ELEM_WIDTH-1:0]      inv_r1c1,
    output logic signed [ELEM_WIDTH-1:0]      inv_r1c2,
    output logic signed [ELEM_WIDTH-1:0]      inv_r2c0,
    output logic signed [ELEM_WIDTH-1:0]      inv_r2c1,
    output logic signed [ELEM_WIDTH-1:0]      inv_r2c2,
    output logic signed [ELEM_WIDTH-1:0]      determinant,
    output logic                              singular
);

    localparam int E    = ELEM_WIDTH;
    localparam int PW   = 2 * E;
    localparam int AW   = 2 * E + 1;
    localparam int PPW  = 2 * E + 1;
    localparam int XW   = 3 * E + 1;
    localparam int DW   = 3 * E + 3;
    localparam int NW   = 4 * E;
    localparam int FL   = m3i_pkg::FRONT_LAT;
    localparam int DLAT = m3i_pkg::div_lat(ELEM_WIDTH);

    logic                 en;
    logic signed [E-1:0]  mx [9];

    logic [FL-1:0]        vld_reg;
    m3i_pkg::ctl_t        ctl_reg [DLAT];

    logic signed [PW-1:0]  p_reg    [18];
    logic signed [E-1:0]   r0_reg   [3];
    logic signed [E-1:0]   r0_d2_reg[3];
    logic signed [AW-1:0]  adj_reg  [9];
    logic signed [AW-1:0]  adj_d3_reg[9];
    logic signed [AW-1:0]  adj_d4_reg[9];
    logic signed [AW-1:0]  adj_d5_reg[9];
    logic signed [PPW-1:0] pl_reg   [3];
    logic signed [PPW-1:0] ph_reg   [3];
    logic signed [XW-1:0]  term_reg [3];
    logic signed [DW-1:0]  det_reg;

    logic                  det_neg_reg;
    logic [DW-1:0]         det_mag_reg;
    logic                  sing_reg;
    logic                  adj_neg_reg[9];
    logic [AW-1:0]         adj_mag_reg[9];

    logic [NW-1:0]         num_w [9];
    logic [DW-1:0]         den_w [9];
    logic                  neg_w [9];
    logic signed [E-1:0]   q_w   [9];

    logic [DW-1:0]         det_sh;
    logic [DW-1:0]         det_rnd;
    logic [DW-1:0]         det_lim;
    logic [DW-1:0]         det_sat;
    logic signed [E-1:0]   det_q_next;
    logic signed [E-1:0]   det_q_reg [DLAT];

    assign mx[0] = m_r0c0;
    assign mx[1] = m_r0c1;
    assign mx[2] = m_r0c2;
    assign mx[3] = m_r1c0;
    assign mx[4] = m_r1c1;
    assign mx[5] = m_r1c2;
    assign mx[6] = m_r2c0;
    assign mx[7] = m_r2c1;
    assign mx[8] = m_r2c2;

    assign en        = inv_ready || !ctl_reg[DLAT-1].valid;
    assign mat_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            for (int j = 0; j < DLAT; j++)
                ctl_reg[j] <= '0;
        end
        else if (en)
        begin
            vld_reg    <= {vld_reg[FL-2:0], mat_valid};
            ctl_reg[0] <= '{valid: vld_reg[FL-1], sing: sing_reg};
            for (int j = 1; j < DLAT; j++)
                ctl_reg[j] <= ctl_reg[j-1];
        end
    end

    // determinant lane: det / 2^(2F), rounded half away from zero on the magnitude
    always_comb
    begin
        det_sh     = det_mag_reg >> (2 * FRAC_BITS);
        det_rnd    = det_sh + DW'(det_mag_reg[2*FRAC_BITS-1]);
        det_lim    = det_neg_reg ? (DW'(1) << (E - 1))
                                 : ((DW'(1) << (E - 1)) - DW'(1));
        det_sat    = (det_rnd > det_lim) ? det_lim : det_rnd;
        det_q_next = det_neg_reg ? E'(-det_sat) : E'(det_sat);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 18; i++)
                p_reg[i] <= mx[m3i_pkg::PROD_A[i]] * mx[m3i_pkg::PROD_B[i]];
            for (int t = 0; t < 3; t++)
                r0_reg[t] <= mx[t];

            for (int k = 0; k < 9; k++)
                adj_reg[k] <= AW'(p_reg[2*k]) - AW'(p_reg[2*k+1]);
            r0_d2_reg <= r0_reg;

            // det = m0*adj0 + m1*adj3 + m2*adj6, each product split in two halves
            for (int t = 0; t < 3; t++)
            begin
                pl_reg[t] <= r0_d2_reg[t] * $signed({1'b0, adj_reg[3*t][E-1:0]});
                ph_reg[t] <= r0_d2_reg[t] * $signed(adj_reg[3*t][AW-1:E]);
            end
            adj_d3_reg <= adj_reg;

            for (int t = 0; t < 3; t++)
                term_reg[t] <= (XW'(ph_reg[t]) <<< E) + XW'(pl_reg[t]);
            adj_d4_reg <= adj_d3_reg;

            det_reg    <= DW'(term_reg[0]) + DW'(term_reg[1]) + DW'(term_reg[2]);
            adj_d5_reg <= adj_d4_reg;

            det_neg_reg <= det_reg[DW-1];
            det_mag_reg <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
            sing_reg    <= (det_reg == '0);
            for (int k = 0; k < 9; k++)
            begin
                adj_neg_reg[k] <= adj_d5_reg[k][AW-1];
                adj_mag_reg[k] <= adj_d5_reg[k][AW-1] ? AW'(-adj_d5_reg[k])
                                                      : AW'(adj_d5_reg[k]);
            end

            det_q_reg[0] <= det_q_next;
            for (int j = 1; j < DLAT; j++)
                det_q_reg[j] <= det_q_reg[j-1];
        end
    end

    always_comb
    begin
        // inverse lanes: adj * 2^(2F) / det
        for (int k = 0; k < 9; k++)
        begin
            num_w[k] = NW'(adj_mag_reg[k]) << (2 * FRAC_BITS);
            den_w[k] = det_mag_reg;
            neg_w[k] = adj_neg_reg[k] ^ det_neg_reg;
        end
    end

    for (genvar g = 0; g < 9; g++)
    begin : g_lane
        m3i_div #(
            .EW   (E),
            .NW   (NW),
            .DENW (DW)
        ) u_div (
            .clk  (clk),
            .en   (en),
            .num  (num_w[g]),
            .den  (den_w[g]),
            .neg  (neg_w[g]),
            .zero (sing_reg),
            .quo  (q_w[g])
        );
    end

    assign inv_valid   = ctl_reg[DLAT-1].valid;
    assign singular    = ctl_reg[DLAT-1].sing;
    assign inv_r0c0    = q_w[0];
    assign inv_r0c1    = q_w[1];
    assign inv_r0c2    = q_w[2];
    assign inv_r1c0    = q_w[3];
    assign inv_r1c1    = q_w[4];
    assign inv_r1c2    = q_w[5];
    assign inv_r2c0    = q_w[6];
    assign inv_r2c1    = q_w[7];
    assign inv_r2c2    = q_w[8];
    assign determinant = det_q_reg[DLAT-1];

endmodule

`default_nettype wire

// File: tb/m3i_checker.sv
// Checker for the 3x3 inverse: predicts every accepted matrix word and compares results.
module m3i_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mat_valid,
    input  logic              mat_ready,
    input  logic [8:0][31:0]  mat,
    input  logic              inv_valid,
    input  logic              inv_ready,
    input  logic [9:0][31:0]  res,
    input  logic              singular,
    output int                fails,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [159:0] wide_t;
    typedef struct packed {
        logic [9:0][31:0] v;
        logic             sing;
    } inv_word_t;

    inv_word_t expected_inverses[$];
    string field_name [10] = '{"inv_r0c0", "inv_r0c1", "inv_r0c2", "inv_r1c0", "inv_r1c1",
                               "inv_r1c2", "inv_r2c0", "inv_r2c1", "inv_r2c2", "determinant"};

    // n/d rounded to nearest, ties away from zero, saturated to 32 bits
    function automatic logic [31:0] round_div_sat(input wide_t n, input wide_t d);
        logic [159:0] na, nd, q, rm, lim;
        logic neg;
        neg = n[159] ^ d[159];
        na = n[159] ? -n : n;
        nd = d[159] ? -d : d;
        q = na / nd;
        rm = na % nd;
        if ((rm << 1) >= nd)
            q = q + 1;
        lim = neg ? 160'h8000_0000 : 160'h7fff_ffff;
        if (q > lim)
            q = lim;
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic inv_word_t predict_inverse(input logic [8:0][31:0] m);
        wide_t e [9];
        wide_t adj [9];
        wide_t det;
        inv_word_t r;
        for (int i = 0; i < 9; i++)
            e[i] = $signed(m[i]);
        adj[0] = e[4] * e[8] - e[7] * e[5];
        adj[1] = e[2] * e[7] - e[1] * e[8];
        adj[2] = e[1] * e[5] - e[2] * e[4];
        adj[3] = e[5] * e[6] - e[3] * e[8];
        adj[4] = e[0] * e[8] - e[2] * e[6];
        adj[5] = e[3] * e[2] - e[0] * e[5];
        adj[6] = e[3] * e[7] - e[6] * e[4];
        adj[7] = e[6] * e[1] - e[0] * e[7];
        adj[8] = e[0] * e[4] - e[3] * e[1];
        det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
        r = '0;
        if (det == 0)
        begin
            r.sing = 1'b1;
        end
        else
        begin
            for (int i = 0; i < 9; i++)
                r.v[i] = round_div_sat(adj[i] <<< 32, det);
            r.v[9] = round_div_sat(det, wide_t'(1) <<< 32);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        inv_word_t want;
        bit bad;
        if (!rst_n)
        begin
            fails <= 0;
            pending <= 0;
        end
        else
        begin
            if (mat_valid && mat_ready)
                expected_inverses.push_back(predict_inverse(mat));
            if (inv_valid && inv_ready)
            begin
                if (expected_inverses.size() == 0)
                begin
                    if (fails < 10)
                        $display("%0t: result word with nothing expected", $time);
                    fails <= fails + 1;
                end
                else
                begin
                    want = expected_inverses.pop_front();
                    bad = 0;
                    for (int i = 0; i < 10; i++)
                        if (res[i] !== want.v[i])
                        begin
                            bad = 1;
                            if (fails < 10)
                                $display("%0t: %s expected %h got %h", $time,
                                         field_name[i], want.v[i], res[i]);
                        end
                    if (singular !== want.sing)
                    begin
                        bad = 1;
                        if (fails < 10)
                            $display("%0t: singular expected %b got %b", $time,
                                     want.sing, singular);
                    end
                    if (bad)
                        fails <= fails + 1;
                end
            end
            pending <= expected_inverses.size();
        end
    end
endmodule

// File: tb/tb_matrix3_inverse.sv
// Testbench top for the 3x3 inverse: stimulus, output stalls and the verdict.
module tb_matrix3_inverse;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1830;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 0;
    logic rst_n = 0;
    logic mat_valid = 0;
    logic inv_ready = 0;
    logic [8:0][31:0] mat = '0;
    wire [9:0][31:0] res;
    wire mat_ready, inv_valid, singular;
    int fails, pending;
    int tx_idle = 0;
    int rx_stall = 0;
    int cycles = 0;
    logic ended = 0;

    always #4 clk = ~clk;

    matrix3_inverse dut (
        .clk(clk), .rst_n(rst_n), .mat_valid(mat_valid), .mat_ready(mat_ready),
        .m_r0c0(mat[0]), .m_r0c1(mat[1]), .m_r0c2(mat[2]),
        .m_r1c0(mat[3]), .m_r1c1(mat[4]), .m_r1c2(mat[5]),
        .m_r2c0(mat[6]), .m_r2c1(mat[7]), .m_r2c2(mat[8]),
        .inv_valid(inv_valid), .inv_ready(inv_ready),
        .inv_r0c0(res[0]), .inv_r0c1(res[1]), .inv_r0c2(res[2]),
        .inv_r1c0(res[3]), .inv_r1c1(res[4]), .inv_r1c2(res[5]),
        .inv_r2c0(res[6]), .inv_r2c1(res[7]), .inv_r2c2(res[8]),
        .determinant(res[9]), .singular(singular)
    );

    m3i_checker chk (
        .clk(clk), .rst_n(rst_n), .mat_valid(mat_valid), .mat_ready(mat_ready),
        .mat(mat), .inv_valid(inv_valid), .inv_ready(inv_ready), .res(res),
        .singular(singular), .fails(fails), .pending(pending)
    );

    always @(posedge clk or negedge rst_n)
        if (!rst_n)
            inv_ready <= 1'b0;
        else
            inv_ready <= ($urandom_range(0, 99) >= rx_stall);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT && !ended)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_matrix(input logic [8:0][31:0] m);
        if ($urandom_range(0, 99) < tx_idle)
        begin
            mat_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        mat <= m;
        mat_valid <= 1'b1;
        do @(posedge clk); while (!mat_ready);
    endtask

    function automatic logic [31:0] small_q(input int span);
        return 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    function automatic logic [8:0][31:0] random_matrix();
        logic [8:0][31:0] m;
        logic [31:0] edges [6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1,
                                   32'hffff_ffff, 32'h0001_0000};
        int mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
            case (mode)
                0, 1, 2: m[i] = $urandom;
                3, 4, 5, 6, 7: m[i] = small_q(262144);
                8: m[i] = small_q(8);
                default: m[i] = edges[$urandom_range(0, 5)];
            endcase
        if (mode == 6)
        begin
            // force a dependent row or a zero column
            if ($urandom_range(0, 1))
                for (int c = 0; c < 3; c++)
                    m[6 + c] = m[c];
            else
                for (int r = 0; r < 3; r++)
                    m[3 * r + 1] = '0;
        end
        if (mode == 7)
            for (int d = 0; d < 3; d++)
                m[4 * d] = m[4 * d] + 32'h0008_0000;
        return m;
    endfunction

    function automatic logic [8:0][31:0] diag(input logic [31:0] a, b, c);
        logic [8:0][31:0] m;
        m = '0;
        m[0] = a;
        m[4] = b;
        m[8] = c;
        return m;
    endfunction

    initial
    begin
        logic [8:0][31:0] m;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity, scaled identity, tiny determinant, rounding ties, extremes, singular
        send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_matrix(diag(32'h0002_0000, 32'hfffe_0000, 32'h0000_8000));
        send_matrix(diag(32'h1, 32'h1, 32'h1));
        send_matrix(diag(32'h0000_8000, 32'h0001_0000, 32'h1));
        send_matrix(diag(32'hffff_8000, 32'h0001_0000, 32'h1));
        send_matrix(diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_matrix(diag(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff));
        send_matrix('0);
        send_matrix({9{32'hffff_ffff}});
        send_matrix({9{32'h8000_0000}});
        m = '0;
        m[2] = 32'h0001_0000;
        m[4] = 32'h0001_0000;
        m[6] = 32'h0001_0000;
        send_matrix(m);
        for (int i = 0; i < 9; i++)
            m[i] = 32'(i + 1) << 16;
        send_matrix(m);
        m[8] = 32'h000a_0000;
        send_matrix(m);
        for (int i = 0; i < 9; i++)
            m[i] = (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
        send_matrix(m);
        send_matrix(diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0100));

        // drain fully before the random phases
        mat_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);

        for (int p = 0; p < 4; p++)
        begin
            tx_idle = (p == 1 || p == 3) ? ((p == 1) ? 64 : 16) : 0;
            rx_stall = (p == 2 || p == 3) ? ((p == 2) ? 64 : 16) : 0;
            for (int k = 0; k < N_RANDOM / 4; k++)
                send_matrix(random_matrix());
        end
        mat_valid <= 1'b0;
        rx_stall = 0;

        do @(posedge clk); while (pending != 0);
        repeat (60) @(posedge clk);
        ended = 1'b1;
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// File: filelist.f
design/m3i_pkg.sv
design/m3i_div.sv
design/matrix3_inverse.sv
tb/m3i_checker.sv
tb/tb_matrix3_inverse.sv
